// ===== rtl/core/assert_macros.svh =====
// Assertion shorthands used by the checker file mgt_checker.sv.
// Needs no other file; take it in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/mgt_pkg.sv =====
// Shared constants and types of the min-gap timestamp table.
// No dependencies; imported by controller, datapath, top level and checker.
package mgt_pkg;

  localparam int GAP_W    = 40;  // min_gap register width
  localparam int IDX_W    = 8;   // read index width
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_CLOSE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch the accepted item, restart the scan
    logic scan_rd;   // read entry at scan pointer, advance pointer
    logic rd_index;  // read entry at the item's index
    logic respond;   // form result, update table and count
  } mgt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;      // scan pointer is at the last stored entry
    logic cnt_zero;  // table is empty
  } mgt_sts_t;

endpackage

// ===== rtl/core/mgt_ctrl.sv =====
// Sequencer of the min-gap timestamp table: one-hot state machine.
// Depends on mgt_pkg (command and status structs, command codes).
module mgt_ctrl import mgt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [CMD_W-1:0] cmd_i,
  input  mgt_sts_t         sts_i,
  output mgt_cmd_t         ctl_o,
  output logic             busy
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_READ  = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          case (cmd_i)
            CMD_ADD:  state_d = sts_i.cnt_zero ? S_RESP : S_SCAN;
            CMD_READ: state_d = S_READ;
            default:  state_d = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        ctl_o.scan_rd = 1'b1;
        if (sts_i.last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_RESP;  // last compare lands here
      S_READ: begin
        ctl_o.rd_index = 1'b1;
        state_d        = S_RESP;
      end
      S_RESP: begin
        ctl_o.respond = 1'b1;
        state_d       = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/core/mgt_datapath.sv =====
// Datapath of the min-gap timestamp table: entry memory, scan pointer,
// gap compare, count and result registers. Depends on mgt_pkg.
module mgt_datapath import mgt_pkg::*; #(
  parameter int CAPACITY  = 256,
  parameter int TIME_BITS = 40
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mgt_cmd_t                    ctl_i,
  output mgt_sts_t                    sts_o,
  input  logic                        cfg_valid_i,
  input  logic [GAP_W-1:0]            cfg_data_i,
  input  logic [CMD_W-1:0]            cmd_i,
  input  logic [TIME_BITS-1:0]        timestamp_i,
  input  logic [IDX_W-1:0]            index_i,
  output logic                        done_o,
  output logic [STATUS_W-1:0]         status_o,
  output logic signed [TIME_BITS:0]   value_o,
  output logic [$clog2(CAPACITY+1)-1:0] count_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = (CW > IDX_W) ? CW : IDX_W;
  localparam int DW = (TIME_BITS > GAP_W) ? TIME_BITS : GAP_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [TIME_BITS-1:0] mem [CAPACITY];

  logic [GAP_W-1:0]     gap_q;
  logic [CMD_W-1:0]     cmd_q;
  logic [TIME_BITS-1:0] ts_q;
  logic [IDX_W-1:0]     idx_q;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        ptr_q;
  logic                 cmp_v_q, close_q;
  logic [TIME_BITS-1:0] rd_data_q;
  logic                 done_q;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [TIME_BITS:0]   value_q, value_d;
  logic [CW-1:0]        res_count_q;

  logic [AW-1:0]        rd_addr;
  logic                 rd_en, wr_en, full, idx_ok, too_close;
  logic [TIME_BITS-1:0] dabs;
  logic [LW-1:0]        idx_ext;

  // config register; always ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else if (cfg_valid_i) begin
      gap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= cmd_i;
      ts_q  <= timestamp_i;
      idx_q <= index_i;
    end
  end

  assign idx_ext = LW'(idx_q);
  assign idx_ok  = idx_ext < LW'(count_q);
  assign full    = (count_q == CAP_C);

  // entry memory, one read and one write port
  assign rd_en   = ctl_i.scan_rd | ctl_i.rd_index;
  assign rd_addr = ctl_i.rd_index ? idx_ext[AW-1:0] : ptr_q;
  assign wr_en   = ctl_i.respond && (cmd_q == CMD_ADD) && !close_q && !full;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AW-1:0]] <= ts_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // scan pointer and sticky too-close flag
  assign dabs      = (rd_data_q >= ts_q) ? (rd_data_q - ts_q) : (ts_q - rd_data_q);
  assign too_close = DW'(dabs) < DW'(gap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      cmp_v_q <= 1'b0;
      close_q <= 1'b0;
    end else begin
      cmp_v_q <= ctl_i.scan_rd;
      if (ctl_i.load) begin
        ptr_q   <= '0;
        close_q <= 1'b0;
      end else begin
        if (ctl_i.scan_rd) begin
          ptr_q <= ptr_q + AW'(1);
        end
        if (cmp_v_q && too_close) begin
          close_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.last     = ((CW'(ptr_q) + CW'(1)) == count_q);
  assign sts_o.cnt_zero = (count_q == '0);

  // result forming
  always_comb begin
    status_d = ST_OK;
    value_d  = '0;
    count_d  = count_q;
    case (cmd_q)
      CMD_ADD: begin
        if (close_q) begin
          status_d = ST_TOO_CLOSE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      CMD_CLEAR: count_d = '0;
      CMD_READ: begin
        if (idx_ok) begin
          value_d = {1'b0, rd_data_q};
        end else begin
          status_d = ST_RANGE;
          value_d  = '1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= ctl_i.respond;
      if (ctl_i.respond) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.respond) begin
      status_q    <= status_d;
      value_q     <= value_d;
      res_count_q <= count_d;
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign value_o  = value_q;
  assign count_o  = res_count_q;

endmodule

// ===== rtl/core/min_gap_timestamp_table.sv =====
// Top level of the min-gap timestamp table: controller plus datapath.
// Depends on mgt_pkg, mgt_ctrl and mgt_datapath.
//
//   channel   direction  handshake                  payload
//   command   in         start, busy                cmd_i, timestamp_i, index_i
//   config    in         cfg_valid_i, cfg_ready_o   cfg_data_i (min_gap)
//   result    out        done_o (one-cycle strobe)  status_o, value_o, count_o
//
// An add scans the stored entries through the single memory read port, one per
// cycle, then compares the registered data of the last entry in the drain state
// and passes through the respond state before the done_o strobe. Add on an
// empty table, clear and unused commands go straight to respond; read first reads the entry at the index.
// busy is high from the cycle after accept until the strobe cycle, when a new
// item may already be accepted. The result registers cannot be stalled.
// Reset clears the count and min_gap; table contents are not cleared, only
// entries below the count are ever scanned or returned. No warm-up pass after reset.
module min_gap_timestamp_table import mgt_pkg::*; #(
  parameter int CAPACITY  = 256,
  parameter int TIME_BITS = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [CMD_W-1:0]              cmd_i,
  input  logic [TIME_BITS-1:0]          timestamp_i,
  input  logic [IDX_W-1:0]              index_i,
  // min_gap write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [GAP_W-1:0]              cfg_data_i,
  // result strobe
  output logic                          done_o,
  output logic [STATUS_W-1:0]           status_o,
  output logic signed [TIME_BITS:0]     value_o,
  output logic [$clog2(CAPACITY+1)-1:0] count_o
);

  mgt_cmd_t ctl;
  mgt_sts_t sts;

  // min_gap may be written at any time the block is idle; no back-pressure
  assign cfg_ready_o = 1'b1;

  mgt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy   (busy)
  );

  // start only matters while idle, which the controller already gates
  mgt_datapath #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd_i),
    .timestamp_i (timestamp_i),
    .index_i     (index_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .value_o     (value_o),
    .count_o     (count_o)
  );

endmodule

// ===== rtl/core/mgt_checker.sv =====
// Port-level checks of min_gap_timestamp_table, bound to the top level.
// Depends on mgt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mgt_checker import mgt_pkg::*; #(
  parameter int CAPACITY  = 256,
  parameter int TIME_BITS = 40
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic [STATUS_W-1:0]           status_o,
  input logic signed [TIME_BITS:0]     value_o,
  input logic [$clog2(CAPACITY+1)-1:0] count_o
);

  localparam int CW = $clog2(CAPACITY + 1);

  // accepted item keeps the block busy next cycle
  `ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  // a result ends a busy period
  `ASSERT_IMP(a_done_after_busy, clk_i, rst_ni, done_o, !busy && $past(busy))
  // out-of-range read returns -1
  `ASSERT_IMP(a_range_value, clk_i, rst_ni, done_o && (status_o == ST_RANGE), &value_o)
  // any other result value is non-negative
  `ASSERT_IMP(a_value_sign, clk_i, rst_ni, done_o && (status_o != ST_RANGE), !value_o[TIME_BITS])
  // count never passes capacity
  `ASSERT_IMP(a_count_cap, clk_i, rst_ni, done_o, count_o <= CW'(CAPACITY))

endmodule

bind min_gap_timestamp_table mgt_checker #(
  .CAPACITY  (CAPACITY),
  .TIME_BITS (TIME_BITS)
) u_mgt_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .status_o (status_o),
  .value_o  (value_o),
  .count_o  (count_o)
);
